// ===== hw/rtl/curve_point_evaluator_top_macros.svh =====
// ----------------------------------------------------------------------------
// curve point evaluator assertion macros
// immediate-implication and next-cycle checks on a clocked, reset-gated property
// ----------------------------------------------------------------------------
`ifndef CURVE_POINT_EVALUATOR_TOP_MACROS_SVH
`define CURVE_POINT_EVALUATOR_TOP_MACROS_SVH

// same-cycle implication
`define CPE_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("curve point evaluator check failed");

// next-cycle implication
`define CPE_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("curve point evaluator check failed");

`endif

// ===== hw/rtl/cpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpe_pkg
// shared constants, command codes and control types of the curve point evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpe_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // width of one operand slice fed to a hardware multiplier
    localparam int CHUNK_W    = 32;
    // headroom bits of the polynomial coefficients over the value width
    localparam int COEF_GUARD = 6;
    localparam int CMD_W      = 3;
    // coefficient stage, three multiply/sum pairs, output stage
    localparam int NUM_STAGES = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LERP      = 3'd0,
        CMD_LERP_FREE = 3'd1,
        CMD_QUAD      = 3'd2,
        CMD_CUBIC     = 3'd3,
        CMD_CATMULL   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic load_mul;
        logic load_sum;
    } step_ctl_t;

endpackage

// ===== hw/rtl/cpe_mac_step.sv =====
// ----------------------------------------------------------------------------
// cpe_mac_step
// one horner step: result = acc * t + (addend << SHIFT), in two register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpe_mac_step
    import cpe_pkg::*;
#(
    parameter int ACC_W = VALUE_WIDTH_DEF + COEF_GUARD,
    parameter int T_W   = VALUE_WIDTH_DEF,
    parameter int ADD_W = VALUE_WIDTH_DEF + COEF_GUARD,
    parameter int SHIFT = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  step_ctl_t                  ctl,
    input  logic signed [ACC_W-1:0]    acc,
    input  logic signed [T_W-1:0]      t,
    input  logic signed [ADD_W-1:0]    addend,
    output logic signed [ACC_W+T_W:0]  result
);

    localparam int NUM_CHUNKS = (ACC_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;
    localparam int PP_W       = CHUNK_W + T_W + 1;
    localparam int RES_W      = ACC_W + T_W + 1;
    localparam int SUM_W      = PAD_W + T_W + 1;

    logic signed [PAD_W-1:0] acc_pad;
    logic signed [PP_W-1:0]  pp_next [NUM_CHUNKS];
    logic signed [PP_W-1:0]  pp_reg  [NUM_CHUNKS];
    logic signed [SUM_W-1:0] sum_next;
    logic signed [RES_W-1:0] sum_reg;

    // partial products: low slices unsigned, top slice carries the sign
    always_comb
    begin
        acc_pad = PAD_W'(acc);
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            if (i == NUM_CHUNKS - 1)
            begin
                pp_next[i] = PP_W'(signed'(acc_pad[i*CHUNK_W +: CHUNK_W])) * PP_W'(t);
            end
            else
            begin
                pp_next[i] = PP_W'($signed({1'b0, acc_pad[i*CHUNK_W +: CHUNK_W]}))
                           * PP_W'(t);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_mul)
        begin
            pp_reg <= pp_next;
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(addend) <<< SHIFT;
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            sum_next = sum_next + (SUM_W'(pp_reg[i]) <<< (i * CHUNK_W));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_sum)
        begin
            sum_reg <= sum_next[RES_W-1:0];
        end
    end

    assign result = sum_reg;

endmodule

// ===== hw/rtl/curve_point_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// curve_point_evaluator_top
// one coordinate of a linear, bezier or catmull-rom curve point per request
// ----------------------------------------------------------------------------
// Takes one request per clock unless the output side stalls, and returns one
// result per request, in order. The curve is turned into a cubic in t with
// exact integer coefficients, then evaluated by three horner multiply-add
// steps; each step is a stage of parallel 32-bit slice multipliers followed by
// a summing stage, and those six stages plus a coefficient stage and a
// round/saturate output register make up the pipeline. Every stage holds its
// own valid bit, so bubbles are squeezed out and a full pipeline with a taken
// output moves one request per cycle.
`timescale 1ns / 1ps

module curve_point_evaluator_top
    import cpe_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [CMD_W-1:0]              cmd,
    input  logic signed [VALUE_WIDTH-1:0] point0,
    input  logic signed [VALUE_WIDTH-1:0] point1,
    input  logic signed [VALUE_WIDTH-1:0] point2,
    input  logic signed [VALUE_WIDTH-1:0] point3,
    input  logic signed [VALUE_WIDTH-1:0] param_t,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] value,
    output logic                          saturated
);

`include "curve_point_evaluator_top_macros.svh"

    localparam int W   = VALUE_WIDTH;
    localparam int KW  = W + COEF_GUARD;
    localparam int H1W = KW + W + 1;
    localparam int H2W = H1W + W + 1;
    localparam int H3W = H2W + W + 1;
    // final scale: every curve is brought to 2^(3F+1)
    localparam int SH  = 3 * FRAC_BITS + 1;

    localparam logic signed [W-1:0]  T_ONE    = {{(W-FRAC_BITS-1){1'b0}}, 1'b1,
                                                 {FRAC_BITS{1'b0}}};
    localparam logic signed [W-1:0]  VAL_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  VAL_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [KW-1:0] HALF_LSB = KW'(1);

    // pipeline control
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES:0]   stage_rdy;

    // coefficients and parameter carried alongside the arithmetic
    logic signed [KW-1:0] k3_reg;
    logic signed [KW-1:0] k2_reg [0:1];
    logic signed [KW-1:0] k1_reg [0:3];
    logic signed [KW-1:0] k0_reg [0:5];
    logic signed [W-1:0]  t_reg  [0:4];

    logic signed [KW-1:0] ea, eb, ec, ed;
    logic signed [KW-1:0] diff_ba, second, third, cr_p2;
    logic signed [KW-1:0] k0_sel;
    logic signed [KW-1:0] k0_next, k1_next, k2_next, k3_next;
    logic signed [W-1:0]  t_next;
    logic                 clamp;

    logic signed [H1W-1:0] h1;
    logic signed [H2W-1:0] h2;
    logic signed [H3W-1:0] h3;
    step_ctl_t             ctl1, ctl2, ctl3;

    logic [H3W-SH-W:0]     h3_top;
    logic                  fits;
    logic signed [W-1:0]   value_next;
    logic                  sat_next;
    logic signed [W-1:0]   value_reg;
    logic                  saturated_reg;

    // a stage may load when it is empty or its successor loads
    always_comb
    begin
        stage_rdy[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_rdy[i] = !v_reg[i] || stage_rdy[i+1];
        end
    end

    always_comb
    begin
        v_next[0] = stage_rdy[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            v_next[i] = stage_rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = v_reg[NUM_STAGES-1];

    // power-basis coefficients, doubled where needed so all curves share one scale
    always_comb
    begin
        ea      = KW'(point0);
        eb      = KW'(point1);
        ec      = KW'(point2);
        ed      = KW'(point3);
        diff_ba = eb - ea;
        second  = ea - (eb <<< 1) + ec;
        third   = (ed - ea) + ((eb - ec) <<< 1) + (eb - ec);
        cr_p2   = (ea <<< 1) - (eb <<< 2) - eb + (ec <<< 2) - ed;
        k0_sel  = '0;
        k1_next = '0;
        k2_next = '0;
        k3_next = '0;
        clamp   = 1'b0;
        case (cmd_t'(cmd))
            CMD_LERP:
            begin
                clamp   = 1'b1;
                k0_sel  = ea <<< 1;
                k1_next = diff_ba <<< 1;
            end
            CMD_LERP_FREE:
            begin
                k0_sel  = ea <<< 1;
                k1_next = diff_ba <<< 1;
            end
            CMD_QUAD:
            begin
                clamp   = 1'b1;
                k0_sel  = ea <<< 1;
                k1_next = diff_ba <<< 2;
                k2_next = second <<< 1;
            end
            CMD_CUBIC:
            begin
                clamp   = 1'b1;
                k0_sel  = ea <<< 1;
                k1_next = (diff_ba <<< 2) + (diff_ba <<< 1);
                k2_next = (second <<< 2) + (second <<< 1);
                k3_next = third <<< 1;
            end
            CMD_CATMULL:
            begin
                k0_sel  = eb <<< 1;
                k1_next = ec - ea;
                k2_next = cr_p2;
                k3_next = third;
            end
            default:
            begin
                clamp = 1'b0;
            end
        endcase
        // half an output lsb folded into the constant term for round-to-nearest
        k0_next = k0_sel + HALF_LSB;

        if (clamp && param_t < 0)
        begin
            t_next = '0;
        end
        else if (clamp && param_t > T_ONE)
        begin
            t_next = T_ONE;
        end
        else
        begin
            t_next = param_t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            k3_reg    <= k3_next;
            k2_reg[0] <= k2_next;
            k1_reg[0] <= k1_next;
            k0_reg[0] <= k0_next;
            t_reg[0]  <= t_next;
        end
        if (stage_rdy[1])
        begin
            k2_reg[1] <= k2_reg[0];
        end
        for (int i = 1; i < 4; i++)
        begin
            if (stage_rdy[i])
            begin
                k1_reg[i] <= k1_reg[i-1];
            end
        end
        for (int i = 1; i < 6; i++)
        begin
            if (stage_rdy[i])
            begin
                k0_reg[i] <= k0_reg[i-1];
            end
        end
        for (int i = 1; i < 5; i++)
        begin
            if (stage_rdy[i])
            begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    assign ctl1 = '{load_mul: stage_rdy[1], load_sum: stage_rdy[2]};
    assign ctl2 = '{load_mul: stage_rdy[3], load_sum: stage_rdy[4]};
    assign ctl3 = '{load_mul: stage_rdy[5], load_sum: stage_rdy[6]};

    cpe_mac_step #(
        .ACC_W (KW),
        .T_W   (W),
        .ADD_W (KW),
        .SHIFT (FRAC_BITS)
    ) u_step1 (
        .clk    (clk),
        .ctl    (ctl1),
        .acc    (k3_reg),
        .t      (t_reg[0]),
        .addend (k2_reg[1]),
        .result (h1)
    );

    cpe_mac_step #(
        .ACC_W (H1W),
        .T_W   (W),
        .ADD_W (KW),
        .SHIFT (2 * FRAC_BITS)
    ) u_step2 (
        .clk    (clk),
        .ctl    (ctl2),
        .acc    (h1),
        .t      (t_reg[2]),
        .addend (k1_reg[3]),
        .result (h2)
    );

    cpe_mac_step #(
        .ACC_W (H2W),
        .T_W   (W),
        .ADD_W (KW),
        .SHIFT (3 * FRAC_BITS)
    ) u_step3 (
        .clk    (clk),
        .ctl    (ctl3),
        .acc    (h2),
        .t      (t_reg[4]),
        .addend (k0_reg[5]),
        .result (h3)
    );

    // drop the scale bits, then saturate if the rest does not fit
    always_comb
    begin
        h3_top = h3[H3W-1:SH+W-1];
        fits   = (&h3_top) || !(|h3_top);
        if (fits)
        begin
            value_next = h3[SH+W-1:SH];
            sat_next   = 1'b0;
        end
        else
        begin
            value_next = h3[H3W-1] ? VAL_MIN : VAL_MAX;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[NUM_STAGES-1])
        begin
            value_reg     <= value_next;
            saturated_reg <= sat_next;
        end
    end

    assign value     = value_reg;
    assign saturated = saturated_reg;

    `CPE_ASSERT_NEXT(a_occupancy, clk, rst_n, 1'b1, $countones(v_reg) == $past($countones(v_reg)) + $past(in_valid && in_ready) - $past(out_valid && out_ready))
    `CPE_ASSERT_NEXT(a_stall_hold, clk, rst_n, v_reg[0] && !stage_rdy[1], v_reg[0] && $stable(k0_reg[0]) && $stable(t_reg[0]))
    `CPE_ASSERT_IMPL(a_sat_rail, clk, rst_n, out_valid && saturated, value == VAL_MAX || value == VAL_MIN)

endmodule

// ===== tb/curve_point_evaluator_top_test.sv =====
// ----------------------------------------------------------------------------
// curve_point_evaluator_top_test
// checks every curve mode, rounding and saturation against an exact predictor
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready sender task. Each accepted request is
// evaluated in wide signed arithmetic and queued; a checking process pops the
// oldest prediction for every result taken and compares value and flag.
// Directed extremes come first, then random curves with random idling on both
// sides, a long output hold-off that backs the pipeline up, and a drain pause.
`timescale 1ns / 1ps

module curve_point_evaluator_top_test
    import cpe_pkg::*;
();

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int VW   = VALUE_WIDTH_DEF;

    localparam logic signed [VW-1:0] ONE     = 1 << FRAC;
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = CMD_W'(CMD_CATMULL + 1);
    localparam logic [CMD_W-1:0] CMD_LAST           = '1;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 saturated;
    } curve_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd = '0;
    logic signed [VW-1:0] point0 = '0;
    logic signed [VW-1:0] point1 = '0;
    logic signed [VW-1:0] point2 = '0;
    logic signed [VW-1:0] point3 = '0;
    logic signed [VW-1:0] param_t = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [VW-1:0] value;
    logic                 saturated;

    curve_result_t expected_points[$];
    int            error_count = 0;
    int            hold_off_cycles = 0;
    bit            idle_on = 1'b1;

    always #5 clk = ~clk;

    curve_point_evaluator_top #(
        .FRAC_BITS   (FRAC),
        .VALUE_WIDTH (VW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .point0    (point0),
        .point1    (point1),
        .point2    (point2),
        .point3    (point3),
        .param_t   (param_t),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .saturated (saturated)
    );

    // exact polynomial over 2^shift, one round half up, then saturation
    function automatic curve_result_t eval_curve(
        input logic [CMD_W-1:0]   op,
        input logic signed [VW-1:0] p0,
        input logic signed [VW-1:0] p1,
        input logic signed [VW-1:0] p2,
        input logic signed [VW-1:0] p3,
        input logic signed [VW-1:0] pt
    );
        wide_t         a, b, c, d, t, u, n, one_w, rounded, vmax, vmin;
        int            shift;
        curve_result_t res;
        a = p0;
        b = p1;
        c = p2;
        d = p3;
        t = pt;
        n = '0;
        shift = 0;
        one_w = wide_t'(1) <<< FRAC;
        if (op == CMD_LERP || op == CMD_QUAD || op == CMD_CUBIC)
        begin
            if (t < 0)
                t = 0;
            if (t > one_w)
                t = one_w;
        end
        u = one_w - t;
        case (op)
            CMD_LERP, CMD_LERP_FREE:
            begin
                n = (a <<< FRAC) + (b - a) * t;
                shift = FRAC;
            end
            CMD_QUAD:
            begin
                n = a * u * u + 2 * b * u * t + c * t * t;
                shift = 2 * FRAC;
            end
            CMD_CUBIC:
            begin
                n = a * u * u * u + 3 * b * u * u * t + 3 * c * u * t * t + d * t * t * t;
                shift = 3 * FRAC;
            end
            CMD_CATMULL:
            begin
                n = ((2 * b) <<< (3 * FRAC))
                  + (((c - a) * t) <<< (2 * FRAC))
                  + (((2 * a - 5 * b + 4 * c - d) * t * t) <<< FRAC)
                  + (-a + 3 * b - 3 * c + d) * t * t * t;
                shift = 3 * FRAC + 1;
            end
            default:
                shift = 0;
        endcase
        res.value = '0;
        res.saturated = 1'b0;
        if (shift != 0)
        begin
            rounded = (n + (wide_t'(1) <<< (shift - 1))) >>> shift;
            vmax = (wide_t'(1) <<< (VW - 1)) - 1;
            vmin = -vmax - 1;
            if (rounded > vmax)
            begin
                res.value = VAL_MAX;
                res.saturated = 1'b1;
            end
            else if (rounded < vmin)
            begin
                res.value = VAL_MIN;
                res.saturated = 1'b1;
            end
            else
            begin
                res.value = rounded[VW-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic signed [VW-1:0] random_point();
        logic signed [VW-1:0] pick;
        case ($urandom_range(0, 5))
            0:       pick = VW'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       pick = VAL_MAX;
                    1:       pick = VAL_MIN;
                    2:       pick = ONE;
                    3:       pick = -ONE;
                    default: pick = '0;
                endcase
            end
            // within about +-32.0 so most curves stay in range
            default: pick = VW'($urandom_range(0, 1 << 22) - (1 << 21));
        endcase
        return pick;
    endfunction

    function automatic logic signed [VW-1:0] random_param();
        logic signed [VW-1:0] pick;
        case ($urandom_range(0, 9))
            0, 1:    pick = VW'($urandom);
            2:       pick = VW'($urandom_range(0, 3 * ONE) - ONE);
            3:       pick = $urandom_range(0, 1) ? ONE : '0;
            default: pick = VW'($urandom_range(0, ONE));
        endcase
        return pick;
    endfunction

    task automatic send_point(
        input logic [CMD_W-1:0]     op,
        input logic signed [VW-1:0] p0,
        input logic signed [VW-1:0] p1,
        input logic signed [VW-1:0] p2,
        input logic signed [VW-1:0] p3,
        input logic signed [VW-1:0] pt
    );
        if (idle_on && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        point0   <= p0;
        point1   <= p1;
        point2   <= p2;
        point3   <= p3;
        param_t  <= pt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_points.push_back(eval_curve(op, p0, p1, p2, p3, pt));
    endtask

    task automatic send_random_curves(input int count);
        logic [CMD_W-1:0] op;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                op = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_LAST));
            else
                op = CMD_W'($urandom_range(CMD_LERP, CMD_CATMULL));
            send_point(op, random_point(), random_point(), random_point(), random_point(),
                       random_param());
        end
    endtask

    task automatic wait_results_done();
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_curve_extremes();
        // lerp endpoints, clamping of t on both sides, rounding ties
        send_point(CMD_LERP, VAL_MIN, VAL_MAX, '0, '0, '0);
        send_point(CMD_LERP, VAL_MIN, VAL_MAX, '0, '0, ONE);
        send_point(CMD_LERP, VAL_MAX, VAL_MIN, '0, '0, VAL_MIN);
        send_point(CMD_LERP, VAL_MAX, VAL_MIN, '0, '0, VAL_MAX);
        send_point(CMD_LERP, '0, 1, '0, '0, ONE >>> 1);
        send_point(CMD_LERP, '0, -1, '0, '0, ONE >>> 1);
        // unclamped blend extrapolates past both ends, saturating or in range
        send_point(CMD_LERP_FREE, VAL_MIN, VAL_MAX, '0, '0, 2 * ONE);
        send_point(CMD_LERP_FREE, VAL_MIN, VAL_MAX, '0, '0, -ONE);
        send_point(CMD_LERP_FREE, ONE, -ONE, '0, '0, VAL_MIN);
        send_point(CMD_LERP_FREE, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
        send_point(CMD_QUAD, VAL_MAX, VAL_MAX, VAL_MAX, '0, ONE >>> 1);
        send_point(CMD_QUAD, VAL_MIN, VAL_MAX, VAL_MIN, '0, VAL_MIN);
        send_point(CMD_QUAD, -ONE, 3 * ONE, ONE, '0, VAL_MAX);
        send_point(CMD_CUBIC, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, ONE / 3);
        send_point(CMD_CUBIC, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, ONE >>> 1);
        send_point(CMD_CUBIC, ONE, -ONE, 2 * ONE, 5, ONE);
        // catmull-rom at its knots and far outside the segment
        send_point(CMD_CATMULL, ONE, 2 * ONE, -3 * ONE, 7, '0);
        send_point(CMD_CATMULL, ONE, 2 * ONE, -3 * ONE, 7, ONE);
        send_point(CMD_CATMULL, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX);
        send_point(CMD_CATMULL, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN);
        send_point(CMD_CATMULL, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, ONE >>> 1);
        for (int op = CMD_RESERVED_FIRST; op <= CMD_LAST; op++)
            send_point(CMD_W'(op), VAL_MAX, VAL_MIN, ONE, -ONE, ONE >>> 1);
    endtask

    task automatic test_random_curves();
        send_random_curves(300);
    endtask

    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        send_random_curves(100);
        idle_on = 1'b1;
    endtask

    // output held off long enough that the pipeline fills and in_ready drops
    task automatic test_output_backpressure();
        hold_off_cycles = 200;
        send_random_curves(40);
    endtask

    task automatic test_drain_pause();
        send_random_curves(30);
        in_valid <= 1'b0;
        wait_results_done();
        send_random_curves(30);
    endtask

    always @(posedge clk)
    begin : result_check
        curve_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("result with no request pending: value %0d saturated %0b",
                       value, saturated);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, value);
                    error_count++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                    error_count++;
                end
            end
        end
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles--;
        end
        else if (idle_on)
        begin
            out_ready <= ($urandom_range(0, 99) >= 15);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_curve_extremes();
        test_random_curves();
        test_no_idle_stretch();
        test_output_backpressure();
        test_drain_pause();
        in_valid <= 1'b0;
        wait_results_done();
        repeat (4 * NUM_STAGES) @(posedge clk);
        if (error_count == 0 && expected_points.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_mac_step.sv
hw/rtl/curve_point_evaluator_top.sv
tb/curve_point_evaluator_top_test.sv
